>>> rtl/core/hiqp_pkg.sv
// ----------------------------------------------------------------------------
// hiqp_pkg
// Shared widths, constants and the command/status structs passed between
// the controller and the datapath of the quadratic-probe insert unit.
// ----------------------------------------------------------------------------
`default_nettype none

package hiqp_pkg;

  localparam int KEY_W  = 31;
  localparam int SIZE_W = 11;
  localparam int SLOT_W = 10;
  localparam int BIT_CNT_W = 5;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd1021;
  localparam logic [SIZE_W-1:0] SIZE_MIN   = 11'd2;
  localparam logic [BIT_CNT_W-1:0] KEY_LAST_BIT = 5'(KEY_W - 1);

  // commands from the controller, at most one work step per cycle
  typedef struct packed {
    logic clr;    // clear one occupancy entry
    logic load;   // latch key and active size, start the mod
    logic div;    // one restoring-division step
    logic seed;   // probe position = home slot
    logic rd;     // read occupancy at probe position
    logic claim;  // mark probe position used and report it
    logic fail;   // report a failed insert
    logic adv;    // move to the next quadratic probe
  } cmd_t;

  // status back to the controller
  typedef struct packed {
    logic clr_last;    // last entry of the clearing pass
    logic div_last;    // last key bit is being consumed
    logic occ;         // registered occupancy of the probe position
    logic probe_last;  // this was probe j = T-1
  } status_t;

endpackage

`default_nettype wire

>>> rtl/core/hiqp_ctrl.sv
// ----------------------------------------------------------------------------
// hiqp_ctrl
// Controller: clearing pass after reset, mod sequencing and the probe walk.
// ----------------------------------------------------------------------------
`default_nettype none

module hiqp_ctrl (
  input  wire              clk,
  input  wire              rst,
  input  wire              start,
  input  hiqp_pkg::status_t st,
  output hiqp_pkg::cmd_t    cmd,
  output logic             busy
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DIV,
    S_SEED,
    S_RD,
    S_CHK
  } state_t;

  state_t state;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      case (state)
        S_CLEAR: if (st.clr_last) state <= S_IDLE;
        S_IDLE:  if (start) state <= S_DIV;
        S_DIV:   if (st.div_last) state <= S_SEED;
        S_SEED:  state <= S_RD;
        S_RD:    state <= S_CHK;
        S_CHK: begin
          if (!st.occ || st.probe_last) state <= S_IDLE;
          else state <= S_RD;
        end
        default: state <= S_CLEAR;
      endcase
    end
  end

  // command decode
  always_comb begin
    cmd = '0;
    case (state)
      S_CLEAR: cmd.clr = 1'b1;
      S_IDLE:  cmd.load = start;
      S_DIV:   cmd.div = 1'b1;
      S_SEED:  cmd.seed = 1'b1;
      S_RD:    cmd.rd = 1'b1;
      S_CHK: begin
        cmd.claim = !st.occ;
        cmd.fail  = st.occ && st.probe_last;
        cmd.adv   = st.occ && !st.probe_last;
      end
      default: cmd = '0;
    endcase
  end

  assign busy = (state != S_IDLE);

  // only one work step per cycle
  a_cmd_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0(cmd))
    else $error("more than one datapath command at once");

  // an accepted item always enters the mod phase
  a_load_div: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> cmd.div)
    else $error("load not followed by division");

  // a probe check comes right after its read
  a_rd_chk: assert property (@(posedge clk) disable iff (rst)
    cmd.rd |=> (cmd.claim || cmd.fail || cmd.adv))
    else $error("read not followed by probe decision");

endmodule

`default_nettype wire

>>> rtl/core/hiqp_datapath.sv
// ----------------------------------------------------------------------------
// hiqp_datapath
// Size register, bit-serial key mod T, incremental quadratic probe address,
// occupancy memory and result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module hiqp_datapath #(
  parameter int TABLE_DEPTH = 1024
) (
  input  wire                             clk,
  input  wire                             rst,
  input  hiqp_pkg::cmd_t                   cmd,
  output hiqp_pkg::status_t                st,
  input  wire                             cfg_we,
  input  wire [hiqp_pkg::SIZE_W-1:0]      cfg_wdata,
  input  wire [hiqp_pkg::KEY_W-1:0]       key,
  output logic                            done,
  output logic [hiqp_pkg::SLOT_W-1:0]     slot,
  output logic                            placed
);

  localparam int ADDR_W   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int SW       = hiqp_pkg::SIZE_W;
  localparam int WIDE_W   = (ADDR_W > SW) ? ADDR_W : SW;
  localparam int LIMIT    = (TABLE_DEPTH > 2047) ? 2047 : TABLE_DEPTH;
  localparam logic [SW-1:0] SIZE_LIM = SW'(LIMIT);
  localparam logic [ADDR_W-1:0] CLR_LAST = ADDR_W'(TABLE_DEPTH - 1);

  logic [SW-1:0] table_size;
  logic [SW-1:0] t_act;
  logic [hiqp_pkg::KEY_W-1:0] key_sh;
  logic [hiqp_pkg::BIT_CNT_W-1:0] bit_cnt;
  logic [SW-1:0] rem;
  logic [SW:0]   trial;
  logic [SW-1:0] rem_next;
  logic [SW-1:0] pos;
  logic [SW-1:0] inc;
  logic [SW-1:0] j_cnt;
  logic [SW:0]   pos_sum;
  logic [SW:0]   inc_sum;
  logic [SW-1:0] pos_next;
  logic [SW-1:0] inc_next;
  logic [WIDE_W-1:0] pos_wide;
  logic [ADDR_W-1:0] pos_addr;
  logic [ADDR_W-1:0] clr_cnt;
  logic occ_mem [TABLE_DEPTH];
  logic occ_rdata;
  logic mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic mem_wdata;

  // size register, written from the config port
  always_ff @(posedge clk) begin
    if (rst) begin
      table_size <= hiqp_pkg::SIZE_RESET;
    end else if (cfg_we) begin
      table_size <= cfg_wdata;
    end
  end

  // key mod T: one restoring step per key bit, msb first
  always_comb begin
    trial = {rem, key_sh[hiqp_pkg::KEY_W-1]};
    if (trial >= {1'b0, t_act}) begin
      rem_next = SW'(trial - {1'b0, t_act});
    end else begin
      rem_next = trial[SW-1:0];
    end
  end

  // next probe: pos += 2j+1 and the odd step += 2, both kept below T
  always_comb begin
    pos_sum = {1'b0, pos} + {1'b0, inc};
    inc_sum = {1'b0, inc} + (SW+1)'(2);
    if (pos_sum >= {1'b0, t_act}) pos_next = SW'(pos_sum - {1'b0, t_act});
    else pos_next = pos_sum[SW-1:0];
    if (inc_sum >= {1'b0, t_act}) inc_next = SW'(inc_sum - {1'b0, t_act});
    else inc_next = inc_sum[SW-1:0];
  end

  assign pos_wide = WIDE_W'(pos);
  assign pos_addr = pos_wide[ADDR_W-1:0];

  // work registers
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clr) begin
      clr_cnt <= clr_cnt + ADDR_W'(1);
    end
    if (cmd.load) begin
      key_sh  <= key;
      bit_cnt <= '0;
      rem     <= '0;
      if (table_size < hiqp_pkg::SIZE_MIN) t_act <= hiqp_pkg::SIZE_MIN;
      else if (table_size > SIZE_LIM) t_act <= SIZE_LIM;
      else t_act <= table_size;
    end
    if (cmd.div) begin
      rem     <= rem_next;
      key_sh  <= {key_sh[hiqp_pkg::KEY_W-2:0], 1'b0};
      bit_cnt <= bit_cnt + hiqp_pkg::BIT_CNT_W'(1);
    end
    if (cmd.seed) begin
      pos   <= rem;
      inc   <= SW'(1);
      j_cnt <= '0;
    end
    if (cmd.adv) begin
      pos   <= pos_next;
      inc   <= inc_next;
      j_cnt <= j_cnt + SW'(1);
    end
  end

  // occupancy memory, one write and one registered read port
  always_comb begin
    mem_we    = cmd.clr || cmd.claim;
    mem_waddr = cmd.clr ? clr_cnt : pos_addr;
    mem_wdata = !cmd.clr;
  end

  always_ff @(posedge clk) begin
    if (mem_we) occ_mem[mem_waddr] <= mem_wdata;
    if (cmd.rd) occ_rdata <= occ_mem[pos_addr];
  end

  // result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.claim || cmd.fail;
    end
    if (cmd.claim) begin
      slot   <= pos_wide[hiqp_pkg::SLOT_W-1:0];
      placed <= 1'b1;
    end else if (cmd.fail) begin
      slot   <= '0;
      placed <= 1'b0;
    end
  end

  // status
  assign st.clr_last   = (clr_cnt == CLR_LAST);
  assign st.div_last   = (bit_cnt == hiqp_pkg::KEY_LAST_BIT);
  assign st.occ        = occ_rdata;
  assign st.probe_last = (j_cnt == t_act - SW'(1));

endmodule

`default_nettype wire

>>> rtl/core/hash_insert_quadratic_probe_unit.sv
// ----------------------------------------------------------------------------
// hash_insert_quadratic_probe_unit
// Inserts one key per item into an occupancy table by quadratic probing.
// ----------------------------------------------------------------------------
// sequence: the item is accepted, then the bit-serial key mod T, a seed step, then a
// read and a check step per probe, P = 1..T probes, then the result strobe
// throughput: one item at a time; the next one may start in the strobe cycle
// reset: the occupancy memory is cleared one entry per cycle, every entry, with busy
// high; table_size resets to 1021; results cannot be stalled
`default_nettype none

module hash_insert_quadratic_probe_unit #(
  parameter int TABLE_DEPTH = 1024
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          start,
  output logic                         busy,
  input  wire [hiqp_pkg::KEY_W-1:0]    key,
  input  wire                          cfg_we,
  input  wire [hiqp_pkg::SIZE_W-1:0]   cfg_wdata,
  output logic                         done,
  output logic [hiqp_pkg::SLOT_W-1:0]  slot,
  output logic                         placed
);

  hiqp_pkg::cmd_t    cmd;
  hiqp_pkg::status_t st;

  hiqp_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .st    (st),
    .cmd   (cmd),
    .busy  (busy)
  );

  hiqp_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .st        (st),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .key       (key),
    .done      (done),
    .slot      (slot),
    .placed    (placed)
  );

  // the strobe comes only after the walk has ended
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while still busy");

  // a failed insert reports slot zero
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !placed) |-> (slot == '0))
    else $error("failed insert with nonzero slot");

  // one strobe per item, never two in a row
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe repeated");

endmodule

`default_nettype wire
